### rtl/assert_macros.svh
// Assertion macros used by the checker file of the token scanner.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted (active low).
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scanner port assertion failed");

// Clocked property checked during reset as well.
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("scanner reset assertion failed");

`endif

### rtl/stsc_pkg.sv
// Shared types and constants of the source token scanner.
// No dependencies; used by every scanner module and the port checker.
`default_nettype none

package stsc_pkg;

    // Scanner modes, one-hot
    typedef enum logic [7:0] {
        MODE_IDLE   = 8'b0000_0001,
        MODE_WORD   = 8'b0000_0010,
        MODE_NUMBER = 8'b0000_0100,
        MODE_STRING = 8'b0000_1000,
        MODE_SLASH  = 8'b0001_0000,
        MODE_LINE   = 8'b0010_0000,
        MODE_BLOCK  = 8'b0100_0000,
        MODE_STAR   = 8'b1000_0000
    } t_mode;

    // Event codes of a result
    localparam logic [2:0] EV_WORDCHAR = 3'd0;
    localparam logic [2:0] EV_WORDEND  = 3'd1;
    localparam logic [2:0] EV_NUMBER   = 3'd2;
    localparam logic [2:0] EV_STRING   = 3'd3;
    localparam logic [2:0] EV_COMMENT  = 3'd4;
    localparam logic [2:0] EV_OTHER    = 3'd5;
    localparam logic [2:0] EV_ERROR    = 3'd6;
    localparam logic [2:0] EV_END      = 3'd7;

    // Error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_OPEN_STR   = 3'd1;
    localparam logic [2:0] ERR_OPEN_BLOCK = 3'd2;
    localparam logic [2:0] ERR_NO_SLASH   = 3'd3;
    localparam logic [2:0] ERR_BAD_SLASH  = 3'd4;

    // Characters of interest
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic [7:0] MAX_WORD_LEN_RST = 8'd32;

    // Result queue depth: two results per step plus headroom
    localparam int unsigned QUEUE_DEPTH = 4;

    // Input request
    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_input;
    } t_in_req;

    // Output request
    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] token_char;
        logic [2:0] error_code;
        logic [7:0] word_length;
        logic       last;
    } t_out_req;

    // Scanner state
    typedef struct packed {
        t_mode      mode;
        logic [7:0] len;
        logic [7:0] first_digit;
    } t_scan_state;

    // Results of one step toward the queue
    typedef struct packed {
        logic     v0;
        logic     v1;
        t_out_req r0;
        t_out_req r1;
    } t_step_out;

endpackage

`default_nettype wire

### rtl/stsc_step.sv
// Next-state and result logic for one scanned byte.
// Depends on stsc_pkg.
`default_nettype none

module stsc_step (
    input  var stsc_pkg::t_scan_state i_st,
    input  var logic [7:0]            i_max_len,
    input  var stsc_pkg::t_in_req     i_req,
    output stsc_pkg::t_scan_state     o_st,
    output stsc_pkg::t_step_out       o_res
);

    function automatic stsc_pkg::t_out_req mk(logic [2:0] ev, logic [7:0] tc,
                                              logic [2:0] err, logic [7:0] len);
        stsc_pkg::t_out_req r;
        r.event_res   = ev;
        r.token_char  = tc;
        r.error_code  = err;
        r.word_length = len;
        r.last        = 1'b0;
        return r;
    endfunction

    logic [7:0] ch;
    logic       eoi;
    logic       is_alpha;
    logic       is_digit;
    logic [7:0] lim;
    logic       rescan;
    logic       c0_v;
    logic       c1_v;
    stsc_pkg::t_out_req c0;
    stsc_pkg::t_out_req c1;
    stsc_pkg::t_out_req c2;
    stsc_pkg::t_out_req r0;
    stsc_pkg::t_out_req r1;
    logic       v1;

    assign ch       = i_req.ch;
    assign eoi      = i_req.end_of_input;
    assign is_alpha = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
    assign is_digit = (ch >= 8'h30 && ch <= 8'h39);
    assign lim      = (i_max_len == 8'd0) ? 8'd1 : i_max_len;

    // Mode handling, idle rescan, end of input
    always_comb begin
        o_st   = i_st;
        c0_v   = 1'b0;
        c0     = '0;
        c1_v   = 1'b0;
        c1     = '0;
        rescan = 1'b0;

        unique case (i_st.mode)
            stsc_pkg::MODE_WORD: begin
                if (!eoi && (is_alpha || is_digit) && i_st.len < lim) begin
                    o_st.len = i_st.len + 8'd1;
                    c0_v     = 1'b1;
                    c0       = mk(stsc_pkg::EV_WORDCHAR, ch, stsc_pkg::ERR_NONE, 8'd0);
                end else begin
                    c0_v      = 1'b1;
                    c0        = mk(stsc_pkg::EV_WORDEND, 8'd0, stsc_pkg::ERR_NONE, i_st.len);
                    o_st.mode = stsc_pkg::MODE_IDLE;
                    o_st.len  = 8'd0;
                    rescan    = !eoi;
                end
            end
            stsc_pkg::MODE_NUMBER: begin
                if (eoi || !is_digit) begin
                    c0_v      = 1'b1;
                    c0        = mk(stsc_pkg::EV_NUMBER, i_st.first_digit,
                                   stsc_pkg::ERR_NONE, 8'd0);
                    o_st.mode = stsc_pkg::MODE_IDLE;
                    rescan    = !eoi;
                end
            end
            stsc_pkg::MODE_STRING: begin
                if (eoi || ch == stsc_pkg::CH_NEWLINE) begin
                    c0_v      = 1'b1;
                    c0        = mk(stsc_pkg::EV_ERROR, 8'd0, stsc_pkg::ERR_OPEN_STR, 8'd0);
                    o_st.mode = stsc_pkg::MODE_IDLE;
                end else if (ch == stsc_pkg::CH_QUOTE) begin
                    c0_v      = 1'b1;
                    c0        = mk(stsc_pkg::EV_STRING, 8'd0, stsc_pkg::ERR_NONE, 8'd0);
                    o_st.mode = stsc_pkg::MODE_IDLE;
                end
            end
            stsc_pkg::MODE_SLASH: begin
                if (!eoi && ch == stsc_pkg::CH_SLASH) begin
                    o_st.mode = stsc_pkg::MODE_LINE;
                end else if (!eoi && ch == stsc_pkg::CH_STAR) begin
                    o_st.mode = stsc_pkg::MODE_BLOCK;
                end else begin
                    c0_v      = 1'b1;
                    c0        = mk(stsc_pkg::EV_ERROR, 8'd0, stsc_pkg::ERR_BAD_SLASH, 8'd0);
                    o_st.mode = stsc_pkg::MODE_IDLE;
                end
            end
            stsc_pkg::MODE_LINE: begin
                if (eoi || ch == stsc_pkg::CH_NEWLINE) begin
                    c0_v      = 1'b1;
                    c0        = mk(stsc_pkg::EV_COMMENT, 8'd0, stsc_pkg::ERR_NONE, 8'd0);
                    o_st.mode = stsc_pkg::MODE_IDLE;
                end
            end
            stsc_pkg::MODE_BLOCK: begin
                if (eoi || ch == stsc_pkg::CH_NEWLINE) begin
                    c0_v      = 1'b1;
                    c0        = mk(stsc_pkg::EV_ERROR, 8'd0, stsc_pkg::ERR_OPEN_BLOCK, 8'd0);
                    o_st.mode = stsc_pkg::MODE_IDLE;
                end else if (ch == stsc_pkg::CH_STAR) begin
                    o_st.mode = stsc_pkg::MODE_STAR;
                end
            end
            stsc_pkg::MODE_STAR: begin
                c0_v      = 1'b1;
                o_st.mode = stsc_pkg::MODE_IDLE;
                if (!eoi && ch == stsc_pkg::CH_SLASH) begin
                    c0 = mk(stsc_pkg::EV_COMMENT, 8'd0, stsc_pkg::ERR_NONE, 8'd0);
                end else begin
                    c0 = mk(stsc_pkg::EV_ERROR, 8'd0, stsc_pkg::ERR_NO_SLASH, 8'd0);
                end
            end
            default: begin
                // idle, and any broken code recovers as idle
                o_st.mode = stsc_pkg::MODE_IDLE;
                rescan    = !eoi;
            end
        endcase

        // Start of a new token from the idle scanner
        if (rescan) begin
            priority if (ch == stsc_pkg::CH_SPACE || ch == stsc_pkg::CH_TAB) begin
                o_st.mode = stsc_pkg::MODE_IDLE;
            end else if (is_alpha) begin
                o_st.mode = stsc_pkg::MODE_WORD;
                o_st.len  = 8'd1;
                c1_v      = 1'b1;
                c1        = mk(stsc_pkg::EV_WORDCHAR, ch, stsc_pkg::ERR_NONE, 8'd0);
            end else if (is_digit) begin
                o_st.mode        = stsc_pkg::MODE_NUMBER;
                o_st.first_digit = ch;
            end else if (ch == stsc_pkg::CH_QUOTE) begin
                o_st.mode = stsc_pkg::MODE_STRING;
            end else if (ch == stsc_pkg::CH_SLASH) begin
                o_st.mode = stsc_pkg::MODE_SLASH;
            end else begin
                c1_v = 1'b1;
                c1   = mk(stsc_pkg::EV_OTHER, ch, stsc_pkg::ERR_NONE, 8'd0);
            end
        end

        if (eoi) begin
            o_st.mode = stsc_pkg::MODE_IDLE;
            o_st.len  = 8'd0;
        end
    end

    assign c2 = mk(stsc_pkg::EV_END, 8'd0, stsc_pkg::ERR_NONE, 8'd0);

    // Pack into two slots; rescan and end never occur together
    always_comb begin
        if (c0_v) begin
            r0 = c0;
            r1 = c1_v ? c1 : c2;
            v1 = c1_v || eoi;
        end else begin
            r0 = c1_v ? c1 : c2;
            r1 = '0;
            v1 = 1'b0;
        end
        r0.last = !v1;
        r1.last = 1'b1;
        o_res.v0 = c0_v || c1_v || eoi;
        o_res.v1 = v1;
        o_res.r0 = r0;
        o_res.r1 = r1;
    end

endmodule

`default_nettype wire

### rtl/stsc_outq.sv
// Result queue: takes up to two results a cycle, hands out one.
// Depends on stsc_pkg.
`default_nettype none

module stsc_outq #(
    parameter int unsigned Depth = stsc_pkg::QUEUE_DEPTH
) (
    input  var logic                i_clk,
    input  var logic                i_rst_n,
    input  var stsc_pkg::t_step_out i_push,
    input  var logic                i_out_ready,
    output logic                    o_room,
    output logic                    o_out_valid,
    output stsc_pkg::t_out_req      o_out_req
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    function automatic logic [PtrW-1:0] nxt(logic [PtrW-1:0] p);
        return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
    endfunction

    stsc_pkg::t_out_req r_mem [Depth];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_cnt;
    logic [PtrW-1:0] wr1;
    logic [CntW-1:0] n_cnt;
    logic            pop;

    assign wr1         = nxt(r_wr);
    assign o_out_valid = (r_cnt != '0);
    assign o_out_req   = r_mem[r_rd];
    assign pop         = o_out_valid && i_out_ready;
    // room for two results, counting the one leaving this cycle
    assign o_room      = (CntW'(Depth) - r_cnt) + CntW'(pop) >= CntW'(2);
    assign n_cnt       = r_cnt + CntW'(i_push.v0) + CntW'(i_push.v1) - CntW'(pop);

    // Payload storage
    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[wr1] <= i_push.r1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.v1) begin
                r_wr <= nxt(wr1);
            end else if (i_push.v0) begin
                r_wr <= wr1;
            end
            if (pop) begin
                r_rd <= nxt(r_rd);
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

### rtl/source_token_scanner.sv
// Source token scanner top level: input register, scan step, result queue.
// An accepted request passes through the input register, then the result queue.
// Throughput: one byte per cycle; a byte waits in the input register only
// while the four-entry result queue lacks room for two more results.
// Reset (synchronous, active low): scanner idle, word length 0, limit 32.
// Depends on stsc_pkg, stsc_step, stsc_outq.
`default_nettype none

module source_token_scanner #(
    parameter int unsigned QueueDepth = stsc_pkg::QUEUE_DEPTH
) (
    input  var logic               i_clk,
    input  var logic               i_rst_n,
    input  var logic               i_in_valid,
    output logic                   o_in_ready,
    input  var stsc_pkg::t_in_req  i_in_req,
    output logic                   o_out_valid,
    input  var logic               i_out_ready,
    output stsc_pkg::t_out_req     o_out_req,
    input  var logic               i_cfg_valid,
    output logic                   o_cfg_ready,
    input  var logic [7:0]         i_cfg_data
);

    logic                  r_in_valid;
    stsc_pkg::t_in_req     r_in;
    stsc_pkg::t_scan_state r_st;
    stsc_pkg::t_scan_state n_st;
    logic [7:0]            r_max_len;
    stsc_pkg::t_step_out   step_res;
    stsc_pkg::t_step_out   push;
    logic                  room;
    logic                  step_fire;

    assign step_fire   = r_in_valid && room;
    assign o_in_ready  = !r_in_valid || step_fire;
    assign o_cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_req;
        end
    end

    // Scanner state and word length limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.mode        <= stsc_pkg::MODE_IDLE;
            r_st.len         <= 8'd0;
            r_st.first_digit <= 8'd0;
            r_max_len        <= stsc_pkg::MAX_WORD_LEN_RST;
        end else begin
            if (step_fire) begin
                r_st <= n_st;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_len <= i_cfg_data;
            end
        end
    end

    stsc_step u_step (
        .i_st      (r_st),
        .i_max_len (r_max_len),
        .i_req     (r_in),
        .o_st      (n_st),
        .o_res     (step_res)
    );

    always_comb begin
        push    = step_res;
        push.v0 = step_res.v0 && step_fire;
        push.v1 = step_res.v1 && step_fire;
    end

    stsc_outq #(
        .Depth (QueueDepth)
    ) u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_out_ready (i_out_ready),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req)
    );

endmodule

`default_nettype wire

### rtl/stsc_checker.sv
// Port checker for the source token scanner, bound to the top level.
// Depends on stsc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module stsc_checker (
    input var logic               i_clk,
    input var logic               i_rst_n,
    input var logic               o_out_valid,
    input var logic               i_out_ready,
    input var stsc_pkg::t_out_req o_out_req
);

    // A stalled result stays put
    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_req))

    // Nothing leaves right after reset
    `ASSERT_CLK(a_rst_quiet, i_clk, !i_rst_n |=> !o_out_valid)

    // Error code only on error results
    `ASSERT_CLK_RST(a_err_only, i_clk, i_rst_n, o_out_valid && o_out_req.event_res != stsc_pkg::EV_ERROR |-> o_out_req.error_code == stsc_pkg::ERR_NONE)

    // Word length only on word end
    `ASSERT_CLK_RST(a_len_only, i_clk, i_rst_n, o_out_valid && o_out_req.event_res != stsc_pkg::EV_WORDEND |-> o_out_req.word_length == 8'd0)

    // End of text is always the final result of its request
    `ASSERT_CLK_RST(a_end_last, i_clk, i_rst_n, o_out_valid && o_out_req.event_res == stsc_pkg::EV_END |-> o_out_req.last)

endmodule

bind source_token_scanner stsc_checker u_stsc_checker (.*);

`default_nettype wire
